>>> sv/rcbp_pkg.sv
// Shared types and constants for the reference-counted buffer pool.
`default_nettype none
package rcbp_pkg;
   localparam int POOL_SLOTS_DEF = 16;
   localparam int SLOT_W         = 8;
   localparam int COUNT_W        = 8;
   localparam logic [COUNT_W-1:0] COUNT_ZERO = 8'h00;
   localparam logic [COUNT_W-1:0] COUNT_FULL = 8'hFF;
   localparam logic [COUNT_W-1:0] COUNT_ONE  = 8'h01;

   typedef enum logic [1:0] {
      ACT_ACQUIRE = 2'd0,
      ACT_INC     = 2'd1,
      ACT_DEC     = 2'd2,
      ACT_READ    = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_NO_FREE = 3'd1,
      ST_RANGE   = 3'd2,
      ST_BAD_INC = 3'd3,
      ST_BAD_DEC = 3'd4
   } status_type;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_EXEC = 1'b1
   } state_type;
endpackage
`default_nettype wire

>>> sv/refcounted_buffer_pool_core.sv
// Top level: reference-counted buffer pool with count memory and result register.
// One request at a time: a request is accepted, the slot's count is read from a
// synchronous count memory into a register, and then in the execute state the
// count is modified, written back and the response is loaded into the output
// register; only then can the next request be accepted, and the count memory is
// read and written once per request. A full output register that is not being
// drained holds the request in flight. Counts start at zero after reset through a
// per-slot in-use bitmap in flip-flops, so no clearing pass is needed. Acquire
// returns the lowest slot with a zero count.
`default_nettype none
module refcounted_buffer_pool_core #(
   parameter int POOL_SLOTS = rcbp_pkg::POOL_SLOTS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] slot
   input  wire logic [1:0]  req_tuser,   // [1:0] action
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [0] ok, [8:1] granted_slot, [16:9] count, [17] still_referenced,
   // [20:18] status, [23:21] zero
   output logic [23:0]      rsp_tdata
);
   import rcbp_pkg::*;

   localparam int IDX_W = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;

   state_type                state_ff, state_in;
   action_type               action_ff;
   logic [SLOT_W-1:0]        slot_ff;
   logic [COUNT_W-1:0]       rd_ff;
   logic [POOL_SLOTS-1:0]    used_ff, used_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [23:0]              rsp_data_ff, rsp_data_in;
   logic [COUNT_W-1:0]       mem [POOL_SLOTS];

   logic                     accept;
   logic                     done;
   logic                     found;
   logic [IDX_W-1:0]         free_idx;
   logic [IDX_W-1:0]         slot_idx;
   logic                     in_range;
   logic [COUNT_W-1:0]       cnt;
   logic                     we;
   logic [IDX_W-1:0]         wr_idx;
   logic [COUNT_W-1:0]       wr_data;
   logic                     r_ok;
   logic [SLOT_W-1:0]        r_slot;
   logic [COUNT_W-1:0]       r_count;
   logic                     r_still;
   status_type               r_status;

   rcbp_find_free #(
      .POOL_SLOTS (POOL_SLOTS),
      .IDX_W      (IDX_W)
   ) u_find_free (
      .used     (used_ff),
      .found    (found),
      .free_idx (free_idx)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign slot_idx = slot_ff[IDX_W-1:0];
   assign in_range = {1'b0, slot_ff} < (SLOT_W + 1)'(POOL_SLOTS);
   // a slot not marked in use reads as zero whatever the memory holds
   assign cnt      = used_ff[slot_idx] ? rd_ff : COUNT_ZERO;

   // response and write-back for the request in the execute cycle
   always_comb begin
      r_ok     = 1'b0;
      r_slot   = slot_ff;
      r_count  = COUNT_ZERO;
      r_still  = 1'b0;
      r_status = ST_OK;
      we       = 1'b0;
      wr_idx   = slot_idx;
      wr_data  = cnt;
      used_in  = used_ff;
      if (action_ff == ACT_ACQUIRE) begin
         if (found) begin
            r_ok     = 1'b1;
            r_slot   = SLOT_W'(free_idx);
            r_count  = COUNT_ONE;
            we       = 1'b1;
            wr_idx   = free_idx;
            wr_data  = COUNT_ONE;
            used_in[free_idx] = 1'b1;
         end else begin
            r_status = ST_NO_FREE;
         end
      end else if (!in_range) begin
         r_status = ST_RANGE;
      end else begin
         unique case (action_ff)
            ACT_INC: begin
               if (cnt == COUNT_ZERO || cnt == COUNT_FULL) begin
                  r_count  = cnt;
                  r_status = ST_BAD_INC;
               end else begin
                  r_ok    = 1'b1;
                  r_count = cnt + COUNT_ONE;
                  we      = 1'b1;
                  wr_data = cnt + COUNT_ONE;
               end
            end
            ACT_DEC: begin
               if (cnt == COUNT_ZERO) begin
                  r_status = ST_BAD_DEC;
               end else begin
                  r_ok    = 1'b1;
                  r_count = cnt - COUNT_ONE;
                  r_still = (cnt != COUNT_ONE);
                  we      = 1'b1;
                  wr_data = cnt - COUNT_ONE;
                  used_in[slot_idx] = (cnt != COUNT_ONE);
               end
            end
            ACT_READ: begin
               r_ok    = 1'b1;
               r_count = cnt;
            end
            default: begin
               r_ok = 1'b0;
            end
         endcase
      end
   end

   // control
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      done         = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (!rsp_valid_ff || rsp_tready) begin
               done         = 1'b1;
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               rsp_data_in  = {3'b000, r_status, r_still, r_count, r_slot, r_ok};
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         used_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (done) begin
            used_ff <= used_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (accept) begin
         action_ff <= action_type'(req_tuser);
         slot_ff   <= req_tdata;
      end
   end

   // count memory: read on accept, write back on completion
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_ff <= mem[req_tdata[IDX_W-1:0]];
      end
      if (done && we) begin
         mem[wr_idx] <= wr_data;
      end
   end
endmodule
`default_nettype wire

>>> sv/rcbp_find_free.sv
// Lowest-index free slot search over the in-use bitmap.
`default_nettype none
module rcbp_find_free #(
   parameter int POOL_SLOTS = rcbp_pkg::POOL_SLOTS_DEF,
   parameter int IDX_W      = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1
) (
   input  wire logic [POOL_SLOTS-1:0] used,
   output logic                       found,
   output logic [IDX_W-1:0]           free_idx
);
   import rcbp_pkg::*;

   always_comb begin
      found    = 1'b0;
      free_idx = '0;
      // scan from the top so the lowest free slot wins
      for (int i = POOL_SLOTS - 1; i >= 0; i--) begin
         if (!used[i]) begin
            found    = 1'b1;
            free_idx = IDX_W'(i);
         end
      end
   end
endmodule
`default_nettype wire

>>> sv/rcbp_checker.sv
// Port-level checks for the buffer pool core, bound to the top level.
`default_nettype none
module rcbp_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [23:0] rsp_tdata
);
   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // only one request in flight
   a_one_inflight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while another is in flight");

   // ok flag agrees with status
   a_ok_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[0] == (rsp_tdata[20:18] == 3'd0)))
      else $error("ok flag disagrees with status");

   // still referenced only on success with a nonzero count
   a_still: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[17] |-> rsp_tdata[0] && (rsp_tdata[16:9] != 8'd0))
      else $error("still_referenced with zero count or error");

   // status code range and zero padding
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[20:18] <= 3'd4) && (rsp_tdata[23:21] == 3'd0))
      else $error("bad status code or padding");
endmodule

bind refcounted_buffer_pool_core rcbp_checker u_rcbp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire

>>> dv/tb.sv
// Self-checking testbench for the reference-counted buffer pool core.
`timescale 1ns / 1ps

module tb;
   import rcbp_pkg::*;

   localparam int POOL_SLOTS = POOL_SLOTS_DEF;
   localparam int NUM_ITEMS  = 2000;

   // matches the rsp_tdata layout, lowest field last
   typedef struct packed {
      logic [2:0]  pad;
      status_type  status;
      logic        still_ref;
      logic [7:0]  count;
      logic [7:0]  slot;
      logic        ok;
   } pool_rsp_type;

   class pool_scoreboard;
      logic [COUNT_W-1:0] counts [POOL_SLOTS];
      pool_rsp_type       pending [$];
      int                 errors;

      function new();
         foreach (counts[i]) counts[i] = COUNT_ZERO;
         errors = 0;
      endfunction

      function void note_request(action_type act, logic [7:0] slot);
         pool_rsp_type r;
         logic      found;
         logic [COUNT_W-1:0] c;
         r = '0;
         r.slot = slot;
         r.status = ST_OK;
         found = 1'b0;
         if (act == ACT_ACQUIRE) begin
            for (int i = 0; i < POOL_SLOTS; i++) begin
               if (!found && counts[i] == COUNT_ZERO) begin
                  counts[i] = COUNT_ONE;
                  r.ok = 1'b1;
                  r.slot = 8'(i);
                  r.count = COUNT_ONE;
                  found = 1'b1;
               end
            end
            if (!found) r.status = ST_NO_FREE;
         end else if (slot >= POOL_SLOTS) begin
            r.status = ST_RANGE;
         end else begin
            c = counts[slot];
            case (act)
               ACT_INC: begin
                  if (c == COUNT_ZERO || c == COUNT_FULL) begin
                     r.status = ST_BAD_INC;
                     r.count = c;
                  end else begin
                     counts[slot] = c + 1'b1;
                     r.ok = 1'b1;
                     r.count = c + 1'b1;
                  end
               end
               ACT_DEC: begin
                  if (c == COUNT_ZERO) begin
                     r.status = ST_BAD_DEC;
                  end else begin
                     counts[slot] = c - 1'b1;
                     r.ok = 1'b1;
                     r.count = c - 1'b1;
                     r.still_ref = (c != COUNT_ONE);
                  end
               end
               default: begin
                  r.ok = 1'b1;
                  r.count = c;
               end
            endcase
         end
         pending.push_back(r);
      endfunction

      function void check_response(logic [23:0] data);
         pool_rsp_type got;
         pool_rsp_type want;
         got = pool_rsp_type'(data);
         if (pending.size() == 0) begin
            if (errors < 10)
               $display("tb: response with nothing outstanding: %h", data);
            errors++;
         end else begin
            want = pending.pop_front();
            if (got !== want) begin
               if (errors < 10) begin
                  $display("tb: mismatch exp ok=%b slot=%0d count=%0d still=%b st=%0d",
                           want.ok, want.slot, want.count, want.still_ref, want.status);
                  $display("tb:          got ok=%b slot=%0d count=%0d still=%b st=%0d pad=%b",
                           got.ok, got.slot, got.count, got.still_ref, got.status,
                           got.pad);
               end
               errors++;
            end
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;   // [7:0] slot
   logic [1:0]  req_tuser = 2'd0;   // [1:0] action
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // [0] ok, [8:1] granted_slot, [16:9] count, [17] still_referenced,
   // [20:18] status, [23:21] zero
   logic [23:0] rsp_tdata;

   pool_scoreboard pool_sb = new();
   int             sent = 0;
   logic           no_idle = 1'b0;

   refcounted_buffer_pool_core #(.POOL_SLOTS(POOL_SLOTS)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("tb: errors");
      $finish;
   end

   // mostly short gaps, a few long ones, none while no_idle is set
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 25);
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) pool_sb.check_response(rsp_tdata);
         if (req_tvalid && req_tready)
            pool_sb.note_request(action_type'(req_tuser), req_tdata);
      end
   end

   // response side back-pressure
   initial begin
      int stall;
      forever begin
         @(posedge clock);
         stall = pick_gap();
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 8) - 1) @(posedge clock);
      end
   end

   // called at a rising edge; returns at the edge that accepts the request
   task automatic send_request(input action_type act, input logic [7:0] slot);
      int   gap;
      logic ready_seen;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= slot;
      do begin
         @(negedge clock);
         ready_seen = req_tready;
         @(posedge clock);
      end while (!ready_seen);
      sent++;
   endtask

   initial begin
      int         r;
      action_type act;
      logic [7:0] slot;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // fill the pool, then one acquire too many
      for (int i = 0; i < POOL_SLOTS; i++) send_request(ACT_ACQUIRE, 8'($urandom));
      send_request(ACT_ACQUIRE, 8'hA5);
      send_request(ACT_INC, 8'd0);
      send_request(ACT_DEC, 8'd0);
      send_request(ACT_DEC, 8'd1);      // last reference dropped
      send_request(ACT_DEC, 8'd1);      // decrement of zero
      send_request(ACT_INC, 8'd1);      // increment of a free slot
      send_request(ACT_READ, 8'd1);
      send_request(ACT_ACQUIRE, 8'd0);  // reuses the freed slot
      send_request(ACT_READ, 8'hFF);
      send_request(ACT_INC, 8'(POOL_SLOTS));
      send_request(ACT_DEC, 8'h80);
      send_request(ACT_READ, 8'(POOL_SLOTS - 1));

      // slot 3 sits at one: ramp it to full, overflow, then drain past zero
      no_idle = 1'b1;
      repeat (255) send_request(ACT_INC, 8'd3);
      no_idle = 1'b0;
      repeat (256) send_request(ACT_DEC, 8'd3);

      while (sent < NUM_ITEMS) begin
         if (sent % 150 == 0) no_idle = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 19) == 0) begin
            // burst of acquires to hit exhaustion
            repeat (POOL_SLOTS + 1) send_request(ACT_ACQUIRE, 8'($urandom));
         end else begin
            r = $urandom_range(0, 99);
            act = (r < 25) ? ACT_ACQUIRE : (r < 50) ? ACT_INC :
                  (r < 80) ? ACT_DEC : ACT_READ;
            if (act == ACT_ACQUIRE || $urandom_range(0, 9) == 0)
               slot = 8'($urandom_range(0, 255));
            else
               slot = 8'($urandom_range(0, POOL_SLOTS - 1));
            send_request(act, slot);
         end
      end
      req_tvalid <= 1'b0;

      while (pool_sb.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (pool_sb.errors == 0 && pool_sb.pending.size() == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule
